// ----- rtl/pal_pkg.sv -----
// Shared types and constants for the positional array list.
// Used by pal_ram, pal_ctrl and positional_array_list; depends on nothing.
`default_nettype none

package pal_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 7;
    localparam int WORD_W       = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op                       op;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic [POS_W-1:0]          found_position;
        logic signed [WORD_W-1:0]  read_value;
        logic [POS_W-1:0]          length;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/pal_ram.sv -----
// Element store: one write port, one read port, registered read data.
// Depends on pal_pkg for the word width.
`default_nettype none

module pal_ram #(
    parameter int DEPTH = pal_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [AW-1:0]                    i_waddr,
    input  wire logic signed [pal_pkg::WORD_W-1:0] i_wdata,
    input  wire logic                             i_re,
    input  wire logic [AW-1:0]                    i_raddr,
    output logic signed [pal_pkg::WORD_W-1:0]     o_rdata
);

    logic signed [pal_pkg::WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pal_ctrl.sv -----
// Sequencer for the list: range checks, shift walks, search walk, get,
// element count and the output register. Depends on pal_pkg; drives pal_ram.
`default_nettype none

module pal_ctrl #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire pal_pkg::t_in_item                 i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output pal_pkg::t_out_item                     o_out_item,
    output logic                                   o_ram_we,
    output logic [AW-1:0]                          o_ram_waddr,
    output logic signed [pal_pkg::WORD_W-1:0]      o_ram_wdata,
    output logic                                   o_ram_re,
    output logic [AW-1:0]                          o_ram_raddr,
    input  wire logic signed [pal_pkg::WORD_W-1:0] i_ram_rdata
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MOVE,
        S_SEARCH,
        S_GET,
        S_DONE
    } t_state;

    t_state             r_state;
    pal_pkg::t_in_item  r_item;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_left;
    logic [AW-1:0]      r_ptr;
    logic               r_pend;
    logic [AW-1:0]      r_wr_addr;
    pal_pkg::t_out_item r_res;

    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] pos_m1;
    logic [CMPW-1:0] cnt_m1;
    logic [CMPW-1:0] ins_moves;
    logic [CMPW-1:0] del_moves;
    logic [CMPW-1:0] found_w;
    logic            pos_zero;
    logic            ins_bad;
    logic            rng_bad;
    logic            is_full;
    logic            walk_issue;
    logic            move_last;

    always_comb begin
        pos_w     = CMPW'(r_item.position);
        cnt_w     = CMPW'(r_count);
        pos_m1    = pos_w - CMPW'(1);
        cnt_m1    = cnt_w - CMPW'(1);
        ins_moves = cnt_w - pos_m1;
        del_moves = cnt_w - pos_w;
        found_w   = CMPW'(r_wr_addr) + CMPW'(1);
        pos_zero  = (r_item.position == '0);
        ins_bad   = pos_zero || (pos_w > cnt_w + CMPW'(1));
        rng_bad   = pos_zero || (pos_w > cnt_w);
        is_full   = (r_count == CW'(CAPACITY));
        walk_issue = ((r_state == S_MOVE) || (r_state == S_SEARCH)) && (r_left != '0);
        move_last  = (r_state == S_MOVE) && (r_left == '0) && !r_pend;
    end

    // RAM access: the walk reads one entry a cycle; a shift walk writes it back in the next cycle
    always_comb begin
        o_ram_re    = walk_issue
                   || ((r_state == S_CHECK) && (r_item.op == pal_pkg::OP_GET) && !rng_bad);
        o_ram_raddr = (r_state == S_CHECK) ? pos_m1[AW-1:0] : r_ptr;
        o_ram_we    = (r_state == S_MOVE)
                   && (r_pend || (move_last && (r_item.op == pal_pkg::OP_INSERT)));
        o_ram_waddr = r_pend ? r_wr_addr : pos_m1[AW-1:0];
        o_ram_wdata = r_pend ? i_ram_rdata : r_item.value;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_CHECK;
                    end
                end

                S_CHECK: begin
                    r_res.found_position <= '0;
                    r_res.read_value     <= '0;
                    r_res.status         <= pal_pkg::ST_OK;
                    r_pend               <= 1'b0;
                    case (r_item.op)
                        pal_pkg::OP_INSERT: begin
                            if (ins_bad) begin
                                r_res.status <= pal_pkg::ST_BAD_POS;
                                r_state      <= S_DONE;
                            end else if (is_full) begin
                                r_res.status <= pal_pkg::ST_FULL;
                                r_state      <= S_DONE;
                            end else begin
                                r_left  <= ins_moves[CW-1:0];
                                r_ptr   <= cnt_m1[AW-1:0];
                                r_state <= S_MOVE;
                            end
                        end
                        pal_pkg::OP_DELETE: begin
                            if (rng_bad) begin
                                r_res.status <= pal_pkg::ST_BAD_POS;
                                r_state      <= S_DONE;
                            end else begin
                                r_left  <= del_moves[CW-1:0];
                                r_ptr   <= pos_w[AW-1:0];
                                r_state <= S_MOVE;
                            end
                        end
                        pal_pkg::OP_SEARCH: begin
                            r_left  <= r_count;
                            r_ptr   <= '0;
                            r_state <= S_SEARCH;
                        end
                        default: begin
                            if (rng_bad) begin
                                r_res.status <= pal_pkg::ST_BAD_POS;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_GET;
                            end
                        end
                    endcase
                end

                S_MOVE: begin
                    // insert walks down, delete walks up
                    r_pend <= walk_issue;
                    if (walk_issue) begin
                        r_left <= r_left - CW'(1);
                        if (r_item.op == pal_pkg::OP_INSERT) begin
                            r_wr_addr <= r_ptr + AW'(1);
                            r_ptr     <= r_ptr - AW'(1);
                        end else begin
                            r_wr_addr <= r_ptr - AW'(1);
                            r_ptr     <= r_ptr + AW'(1);
                        end
                    end
                    if (move_last) begin
                        if (r_item.op == pal_pkg::OP_INSERT) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_count <= r_count - CW'(1);
                        end
                        r_state <= S_DONE;
                    end
                end

                S_SEARCH: begin
                    r_pend <= walk_issue;
                    if (walk_issue) begin
                        r_left    <= r_left - CW'(1);
                        r_wr_addr <= r_ptr;
                        r_ptr     <= r_ptr + AW'(1);
                    end
                    if (r_pend && (i_ram_rdata == r_item.value)) begin
                        r_res.found_position <= found_w[pal_pkg::POS_W-1:0];
                        r_pend               <= 1'b0;
                        r_state              <= S_DONE;
                    end else if (!r_pend && (r_left == '0)) begin
                        r_res.status <= pal_pkg::ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end
                end

                S_GET: begin
                    r_res.read_value <= i_ram_rdata;
                    r_state          <= S_DONE;
                end

                S_DONE: begin
                    // hold until the output register is free
                    if (!o_out_valid || i_out_ready) begin
                        o_out_item.status         <= r_res.status;
                        o_out_item.found_position <= r_res.found_position;
                        o_out_item.read_value     <= r_res.read_value;
                        o_out_item.length         <= cnt_w[pal_pkg::POS_W-1:0];
                        o_out_valid               <= 1'b1;
                        r_state                   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MOVE) |-> !o_ram_we)
        else $error("element store written outside a shift walk");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_w <= CMPW'(CAPACITY))
        else $error("element count above capacity");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && o_ram_re) |-> (o_ram_waddr != o_ram_raddr))
        else $error("read and write of the same entry in one cycle");

    a_new_word_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && !r_pend) |-> (r_item.op == pal_pkg::OP_INSERT))
        else $error("new word written by an operation other than insert");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_count))
        else $error("element count changed while idle");
`endif

endmodule

`default_nettype wire

// ----- rtl/positional_array_list.sv -----
// Ordered list of signed 32-bit words with insert, delete, search and get.
// Input channel i_in_valid/o_in_ready carries one t_in_item per beat: op,
// 1-based position and value. Output channel o_out_valid/i_out_ready
// carries one t_out_item per input beat: status, found position, read value
// and the list length after the operation. Results come out in input order.
// One item is worked at a time. A rejected operation goes straight to its
// result; get reads one entry. Insert shifts the entries from the position
// to the end up by one, delete shifts the entries after it down by one, and
// search walks from position 1 up to the first match or the end of the list.
// The walks move one entry a cycle, set by the single read port and single
// write port of the element store. A new input beat is taken as soon as the
// previous result is in the output register, even if it is not yet taken.
// When the receiver stalls, a finished result waits in the output register
// and the next item stops at its end until that register is free.
// Reset (i_rst_n low, synchronous) empties the list at once; store contents
// are never cleared, since only entries below the length are ever read.
// Depends on pal_pkg, pal_ctrl and pal_ram.
`default_nettype none

module positional_array_list #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire pal_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output pal_pkg::t_out_item      o_out_item
);

    localparam int AW = $clog2(CAPACITY);

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic signed [pal_pkg::WORD_W-1:0] ram_wdata;
    logic                              ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic signed [pal_pkg::WORD_W-1:0] ram_rdata;

    pal_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    pal_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
